/* design/bdc_pkg.sv */
// Shared types and constants for the button debounce / click detector.
// No dependencies; used by every module of the block.
`default_nettype none

package bdc_pkg;

    localparam int BUTTON_W    = 3;   // width of button_index / event_button
    localparam int NOW_W       = 32;  // width of the sample timestamp
    localparam int CFG_W       = 16;  // width of a configuration register
    localparam int CFG_INDEX_W = 1;
    localparam int S_TDATA_W   = 40;  // level + now_ms, padded to bytes
    localparam int M_TDATA_W   = 8;   // event_button, padded to bytes
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE_DELAY = 1'b0,
        CFG_LONG_PRESS     = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_CLICK   = 2'd2,
        KIND_LONG    = 2'd3
    } kind_t;

    // One queued event record: a press alone, or a click/long click
    // that is followed by a release.
    typedef struct packed {
        logic [BUTTON_W-1:0] button;
        kind_t               kind;
        logic                pair;
    } event_rec_t;

endpackage

`default_nettype wire

/* design/bdc_front.sv */
// Front end: per-button debounce state and event classification.
// Depends on bdc_pkg. Pushes event records into bdc_queue.
`default_nettype none

module bdc_front #(
    parameter int NUM_BUTTONS = 8,
    parameter int TIME_WIDTH  = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         take,        // sample transaction this edge
    input  wire logic [bdc_pkg::BUTTON_W-1:0] button_index,
    input  wire logic                         level,
    input  wire logic [bdc_pkg::NOW_W-1:0]    now_ms,
    input  wire logic [bdc_pkg::CFG_W-1:0]    debounce_delay,
    input  wire logic [bdc_pkg::CFG_W-1:0]    long_press,
    output logic                              push,
    output bdc_pkg::event_rec_t               rec
);

    // Only indexes reachable through the 3-bit field need storage.
    localparam int DEPTH = (NUM_BUTTONS < (1 << bdc_pkg::BUTTON_W)) ?
                           NUM_BUTTONS : (1 << bdc_pkg::BUTTON_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  acc_level_reg   [DEPTH];
    logic                  cand_level_reg  [DEPTH];
    logic [TIME_WIDTH-1:0] cand_since_reg  [DEPTH];
    logic [TIME_WIDTH-1:0] pressed_at_reg  [DEPTH];

    logic                  in_range;
    logic [IDX_W-1:0]      idx;
    logic [TIME_WIDTH-1:0] now_t;
    logic                  acc_lvl;
    logic                  cand_lvl;
    logic [TIME_WIDTH-1:0] since;
    logic [TIME_WIDTH-1:0] pressed;
    logic [TIME_WIDTH:0]   since_diff;   // MSB is the borrow: timestamp went backward
    logic                  backward;
    logic [TIME_WIDTH-1:0] held;
    logic                  debounced;
    logic                  is_long;
    logic                  differs;
    logic                  new_cand;
    logic                  accept_lvl;

    always_comb
    begin
        in_range  = 32'(button_index) < 32'(NUM_BUTTONS);
        idx       = button_index[IDX_W-1:0];
        now_t     = TIME_WIDTH'({32'd0, now_ms});
        acc_lvl   = acc_level_reg[idx];
        cand_lvl  = cand_level_reg[idx];
        since     = cand_since_reg[idx];
        pressed   = pressed_at_reg[idx];

        since_diff = {1'b0, now_t} - {1'b0, since};
        backward   = since_diff[TIME_WIDTH];
        // after a backward step the candidate restarts at now: zero elapsed
        debounced  = !backward &&
                     (since_diff[TIME_WIDTH-1:0] > TIME_WIDTH'(debounce_delay));
        held       = now_t - pressed;
        is_long    = held > TIME_WIDTH'(long_press);

        differs    = take && in_range && (level != acc_lvl);
        new_cand   = differs && (level != cand_lvl);
        accept_lvl = differs && !new_cand && debounced;

        push       = accept_lvl;
        rec.button = button_index;
        rec.pair   = level;
        if (level)
        begin
            rec.kind = is_long ? bdc_pkg::KIND_LONG : bdc_pkg::KIND_CLICK;
        end
        else
        begin
            rec.kind = bdc_pkg::KIND_PRESS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                acc_level_reg[i]  <= 1'b1;
                cand_level_reg[i] <= 1'b1;
                cand_since_reg[i] <= '0;
                pressed_at_reg[i] <= '0;
            end
        end
        else if (differs)
        begin
            if (new_cand)
            begin
                cand_level_reg[idx] <= level;
                cand_since_reg[idx] <= now_t;
            end
            else if (accept_lvl)
            begin
                acc_level_reg[idx] <= level;
                if (!level)
                begin
                    pressed_at_reg[idx] <= now_t;
                end
            end
            else if (backward)
            begin
                cand_since_reg[idx] <= now_t;
            end
        end
    end

endmodule

`default_nettype wire

/* design/bdc_queue.sv */
// Short FIFO of event records between the front end and the output stage.
// Depends on bdc_pkg.
`default_nettype none

module bdc_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  bdc_pkg::event_rec_t       push_rec,
    input  wire logic                 pop,
    output bdc_pkg::event_rec_t       head,
    output logic                      empty,
    output logic                      full
);

    localparam int PTR_W = (bdc_pkg::QUEUE_DEPTH > 1) ? $clog2(bdc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(bdc_pkg::QUEUE_DEPTH + 1);

    bdc_pkg::event_rec_t mem [bdc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_next;
    logic                do_push;
    logic                do_pop;

    always_comb
    begin
        empty   = (count_reg == '0);
        full    = (count_reg == CNT_W'(bdc_pkg::QUEUE_DEPTH));
        head    = mem[rd_ptr_reg];
        do_push = push && !full;
        do_pop  = pop && !empty;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(bdc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(bdc_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* design/bdc_back.sv */
// Back end: expands queued records into output event beats.
// Depends on bdc_pkg. Owns the output register of the event stream.
`default_nettype none

module bdc_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  bdc_pkg::event_rec_t                head,
    input  wire logic                          empty,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bdc_pkg::BUTTON_W-1:0]       out_button,
    output bdc_pkg::kind_t                     out_kind,
    output logic                               out_last
);

    logic                          valid_reg;
    logic [bdc_pkg::BUTTON_W-1:0]  button_reg;
    bdc_pkg::kind_t                kind_reg;
    logic                          last_reg;
    logic                          phase_reg;   // 1: release half of a pair is next
    logic                          load;

    always_comb
    begin
        load = !valid_reg || out_ready;
        pop  = load && !empty && (phase_reg || !head.pair);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !empty;
            if (!empty)
            begin
                phase_reg <= !phase_reg && head.pair;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            button_reg <= head.button;
            if (phase_reg)
            begin
                kind_reg <= bdc_pkg::KIND_RELEASE;
                last_reg <= 1'b1;
            end
            else
            begin
                kind_reg <= head.kind;
                last_reg <= !head.pair;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign out_button = button_reg;
    assign out_kind   = kind_reg;
    assign out_last   = last_reg;

endmodule

`default_nettype wire

/* design/button_debounce_click_detector.sv */
// Top level of the button debounce / click detector.
// Depends on bdc_pkg, bdc_front, bdc_queue and bdc_back.
//
// Usage:
//   s_axis: one button sample per transaction. tuser = button_index,
//     tdata = level (0 pressed) and the millisecond timestamp now_ms.
//   m_axis: events. tdata = event_button, tuser = event_kind
//     (press, release, click, long click), tlast marks the final event of
//     the sample. A released button yields click or long click, then release.
//   cfg: register writes (index 0 debounce delay, index 1 long-press time),
//     always ready; write only while no events are in flight.
// Timing:
//   A sample is classified in the cycle it is accepted; its first event goes
//   to m_axis through the queue and the output register. Samples are taken
//   one per cycle while the 2-entry event queue has room; the output register
//   moves one event per cycle while m_axis_tready is high; a release yields two.
// Reset: all buttons released, timers zero, registers 50 ms and 1000 ms.
// Stall: when m_axis_tready is low the queue fills and s_axis_tready drops;
//   samples that produce no event still need a free queue slot to enter.
`default_nettype none

module button_debounce_click_detector #(
    parameter int NUM_BUTTONS = 8,
    parameter int TIME_WIDTH  = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // sample stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [bdc_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [0] level, [32:1] now_ms
    input  wire logic [bdc_pkg::BUTTON_W-1:0]      s_axis_tuser,  // [2:0] button_index
    // event stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [bdc_pkg::M_TDATA_W-1:0]          m_axis_tdata,  // [2:0] event_button
    output logic [1:0]                             m_axis_tuser,  // [1:0] event_kind
    output logic                                   m_axis_tlast,  // last_of_run
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bdc_pkg::CFG_W-1:0]         cfg_data
);

    logic [bdc_pkg::CFG_W-1:0]     debounce_reg;
    logic [bdc_pkg::CFG_W-1:0]     long_press_reg;
    logic                          take;
    logic                          q_push;
    bdc_pkg::event_rec_t           q_push_rec;
    logic                          q_pop;
    bdc_pkg::event_rec_t           q_head;
    logic                          q_empty;
    logic                          q_full;
    logic [bdc_pkg::BUTTON_W-1:0]  ev_button;
    bdc_pkg::kind_t                ev_kind;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !q_full;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= bdc_pkg::DEBOUNCE_RESET;
            long_press_reg <= bdc_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (bdc_pkg::cfg_reg_t'(cfg_index))
                bdc_pkg::CFG_DEBOUNCE_DELAY: debounce_reg   <= cfg_data;
                bdc_pkg::CFG_LONG_PRESS:     long_press_reg <= cfg_data;
                default:                     ;
            endcase
        end
    end

    bdc_front #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .button_index   (s_axis_tuser),
        .level          (s_axis_tdata[0]),
        .now_ms         (s_axis_tdata[bdc_pkg::NOW_W:1]),
        .debounce_delay (debounce_reg),
        .long_press     (long_press_reg),
        .push           (q_push),
        .rec            (q_push_rec)
    );

    bdc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_push_rec),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    bdc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .empty      (q_empty),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_button (ev_button),
        .out_kind   (ev_kind),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = bdc_pkg::M_TDATA_W'(ev_button);
    assign m_axis_tuser = ev_kind;

    // a record is never offered to a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("event queue overflow");

    // only a click or long click is followed by another event of the same sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
        (m_axis_tuser == bdc_pkg::KIND_CLICK || m_axis_tuser == bdc_pkg::KIND_LONG))
        else $error("non-final event is not a click");

    // the release of a pair follows right after its click, for the same button
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tlast && m_axis_tuser == bdc_pkg::KIND_RELEASE &&
         m_axis_tdata == $past(m_axis_tdata)))
        else $error("release does not follow click");

endmodule

`default_nettype wire
